/* rtl/tcp_header_parse_check_defines.svh */
// Assertion macros for the checker file of the TCP header parser.
`ifndef TCP_HEADER_PARSE_CHECK_DEFINES_SVH
`define TCP_HEADER_PARSE_CHECK_DEFINES_SVH

// Clocked assertion that is switched off while reset is asserted.
`define TCPHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define TCPHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

/* rtl/tcphp_pkg.sv */
package tcphp_pkg;

  // Width of the saturating byte position counter.
  localparam int unsigned PosBits = 16;
  localparam logic [PosBits-1:0] PosMax = {PosBits{1'b1}};

  // Fixed part of the TCP header.
  localparam int unsigned FixedHeaderBytes = 20;
  localparam logic [3:0] MinOffsetWords = 4'(FixedHeaderBytes / 4);

  // Final status of a segment.
  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StBadSum  = 2'd1,
    StTrunc   = 2'd2,
    StOffset  = 2'd3
  } status_e;

  // One input item.
  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [31:0] pseudo_sum;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        done_res;
    status_e     status;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] seq_number;
    logic [31:0] ack_number;
    logic [3:0]  flag_bits;
    logic [15:0] window;
  } res_t;

endpackage

/* rtl/tcphp_parse.sv */
module tcphp_parse (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tcphp_pkg::item_t item_i,
  input  logic           adv_i,
  output tcphp_pkg::res_t  res_o,
  output logic           has_res_o
);
  import tcphp_pkg::*;

  // Segment state.
  logic [PosBits-1:0] pos_q, pos_d;
  logic               phase_q, phase_d;
  logic [31:0]        acc_q, acc_d;
  logic [7:0]         hold_q, hold_d;
  logic [15:0]        src_q, src_d;
  logic [15:0]        dst_q, dst_d;
  logic [31:0]        seq_q, seq_d;
  logic [31:0]        ack_q, ack_d;
  logic [3:0]         off_q, off_d;
  logic [3:0]         flags_q, flags_d;
  logic [15:0]        win_q, win_d;

  logic               first;
  logic               phase_cur;
  logic [31:0]        acc_base;
  logic [15:0]        addend;
  logic [32:0]        sum_raw;
  logic [16:0]        fold1;
  logic [15:0]        fold2;
  logic               payload;
  logic [PosBits:0]   seg_len;
  logic [PosBits:0]   need_len;
  status_e            status;
  logic [7:0]         b;

  assign b     = item_i.data_byte;
  assign first = (pos_q == '0);

  // Next segment state: a new segment restarts the sum and clears the fields.
  always_comb begin
    acc_base  = first ? item_i.pseudo_sum : acc_q;
    phase_cur = first ? 1'b0 : phase_q;
    src_d     = first ? 16'h0 : src_q;
    dst_d     = first ? 16'h0 : dst_q;
    seq_d     = first ? 32'h0 : seq_q;
    ack_d     = first ? 32'h0 : ack_q;
    off_d     = first ? 4'h0 : off_q;
    flags_d   = first ? 4'h0 : flags_q;
    win_d     = first ? 16'h0 : win_q;
    hold_d    = hold_q;
    payload   = 1'b0;

    // Pair bytes into big-endian words; an odd last byte gets a zero low byte.
    if (!phase_cur) begin
      hold_d  = b;
      phase_d = 1'b1;
      addend  = item_i.last_byte ? {b, 8'h00} : 16'h0000;
    end else begin
      phase_d = 1'b0;
      addend  = {hold_q, b};
    end
    sum_raw = {1'b0, acc_base} + {17'h0, addend};
    acc_d   = sum_raw[31:0] + {31'h0, sum_raw[32]};

    // Header field capture by byte position.
    if (pos_q < PosBits'(2)) begin
      src_d = {src_d[7:0], b};
    end else if (pos_q < PosBits'(4)) begin
      dst_d = {dst_d[7:0], b};
    end else if (pos_q < PosBits'(8)) begin
      seq_d = {seq_d[23:0], b};
    end else if (pos_q < PosBits'(12)) begin
      ack_d = {ack_d[23:0], b};
    end else if (pos_q == PosBits'(12)) begin
      off_d = b[7:4];
    end else if (pos_q == PosBits'(13)) begin
      flags_d = {b[4], b[2:0]};
    end else if (pos_q < PosBits'(16)) begin
      win_d = {win_d[7:0], b};
    end else if (off_d >= MinOffsetWords && pos_q >= PosBits'({off_d, 2'b00})) begin
      payload = 1'b1;
    end

    // Position counter saturates and restarts after the last byte.
    if (item_i.last_byte) begin
      pos_d = '0;
    end else if (pos_q != PosMax) begin
      pos_d = pos_q + PosBits'(1);
    end else begin
      pos_d = pos_q;
    end
  end

  // Final status: fold the sum to 16 bits, then check lengths and offset.
  always_comb begin
    fold1    = {1'b0, acc_d[31:16]} + {1'b0, acc_d[15:0]};
    fold2    = fold1[15:0] + {15'h0, fold1[16]};
    seg_len  = {1'b0, pos_q} + (PosBits + 1)'(1);
    need_len = (PosBits + 1)'({off_d, 2'b00});
    if (fold2 != 16'hFFFF) begin
      status = StBadSum;
    end else if (seg_len < (PosBits + 1)'(FixedHeaderBytes)) begin
      status = StTrunc;
    end else if (off_d < MinOffsetWords) begin
      status = StOffset;
    end else if (seg_len < need_len) begin
      status = StTrunc;
    end else begin
      status = StOk;
    end
  end

  // Result item; fields not carried read as zero.
  always_comb begin
    has_res_o           = payload || item_i.last_byte;
    res_o               = '0;
    res_o.payload_byte  = payload ? b : 8'h00;
    res_o.payload_valid = payload;
    if (item_i.last_byte) begin
      res_o.done_res    = 1'b1;
      res_o.status      = status;
      res_o.source_port = src_d;
      res_o.dest_port   = dst_d;
      res_o.seq_number  = seq_d;
      res_o.ack_number  = flags_d[3] ? ack_d : 32'h0;
      res_o.flag_bits   = flags_d;
      res_o.window      = win_d;
    end
  end

  // Control state resets; the rest is rewritten at the start of a segment.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      phase_q <= 1'b0;
    end else if (adv_i) begin
      pos_q   <= pos_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      acc_q   <= acc_d;
      hold_q  <= hold_d;
      src_q   <= src_d;
      dst_q   <= dst_d;
      seq_q   <= seq_d;
      ack_q   <= ack_d;
      off_q   <= off_d;
      flags_q <= flags_d;
      win_q   <= win_d;
    end
  end

endmodule

/* rtl/tcp_header_parse_check.sv */
// Channel  Direction  Handshake               Payload
// in       sink       in_valid_i / in_stall_o  data_byte, last_byte, pseudo_sum
// out      source     out_valid_o / out_stall_i payload_byte .. window
//
// One byte is taken every cycle unless the input stalls; a result passes the input register, then the result register.
// The rate is set by the per-byte checksum add and field capture in tcphp_parse.
// Reset is asynchronous and active low; it empties both stages and starts a
// new segment. No clearing pass is needed after reset.
// A stall on the output holds the result register; the input stalls only when
// its register holds a byte with a result that cannot move on.
module tcp_header_parse_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] pseudo_sum_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  payload_byte_o,
  output logic        payload_valid_o,
  output logic        done_res_o,
  output logic [1:0]  status_o,
  output logic [15:0] source_port_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] seq_number_o,
  output logic [31:0] ack_number_o,
  output logic [3:0]  flag_bits_o,
  output logic [15:0] window_o
);
  import tcphp_pkg::*;

  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  res_t  out_res_q;
  res_t  res;
  logic  has_res;
  logic  adv;

  // The held item moves on unless its result meets a full, stalled output.
  assign adv        = in_valid_q && (!has_res || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      in_item_q <= '{data_byte: data_byte_i, last_byte: last_byte_i,
                     pseudo_sum: pseudo_sum_i};
    end
  end

  tcphp_parse u_parse (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .item_i    (in_item_q),
    .adv_i     (adv),
    .res_o     (res),
    .has_res_o (has_res)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv && has_res) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      out_res_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign payload_byte_o  = out_res_q.payload_byte;
  assign payload_valid_o = out_res_q.payload_valid;
  assign done_res_o      = out_res_q.done_res;
  assign status_o        = out_res_q.status;
  assign source_port_o   = out_res_q.source_port;
  assign dest_port_o     = out_res_q.dest_port;
  assign seq_number_o    = out_res_q.seq_number;
  assign ack_number_o    = out_res_q.ack_number;
  assign flag_bits_o     = out_res_q.flag_bits;
  assign window_o        = out_res_q.window;

endmodule

/* rtl/tcphp_checker.sv */
`include "tcp_header_parse_check_defines.svh"

module tcphp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_stall_i,
  input logic [7:0]  payload_byte_i,
  input logic        payload_valid_i,
  input logic        done_res_i,
  input logic [1:0]  status_i,
  input logic [15:0] source_port_i,
  input logic [15:0] dest_port_i,
  input logic [31:0] seq_number_i,
  input logic [31:0] ack_number_i,
  input logic [3:0]  flag_bits_i,
  input logic [15:0] window_i
);
  import tcphp_pkg::*;

  // A stalled result item stays in place.
  `TCPHP_ASSERT(a_out_hold, out_valid_i && out_stall_i |=> out_valid_i && $stable(payload_byte_i) && $stable(done_res_i) && $stable(status_i) && $stable(seq_number_i), "stalled result item changed")

  // Every result item carries a payload byte or the end of a segment.
  `TCPHP_ASSERT(a_out_reason, out_valid_i |-> payload_valid_i || done_res_i, "result item with neither payload nor end of segment")

  // Header fields and status are zero on a pure payload item.
  `TCPHP_ASSERT(a_fields_zero, out_valid_i && !done_res_i |-> status_i == 2'd0 && source_port_i == 16'h0 && dest_port_i == 16'h0 && seq_number_i == 32'h0 && ack_number_i == 32'h0 && flag_bits_i == 4'h0 && window_i == 16'h0, "header fields set without end of segment")

  // The acknowledgement number reads zero without ACK, and no stray payload byte.
  `TCPHP_ASSERT(a_ack_gate, out_valid_i && ((!flag_bits_i[3] && ack_number_i != 32'h0) || (!payload_valid_i && payload_byte_i != 8'h00)) |-> 1'b0, "ack number or payload byte not gated")

endmodule

bind tcp_header_parse_check tcphp_checker u_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .payload_byte_i  (payload_byte_o),
  .payload_valid_i (payload_valid_o),
  .done_res_i      (done_res_o),
  .status_i        (status_o),
  .source_port_i   (source_port_o),
  .dest_port_i     (dest_port_o),
  .seq_number_i    (seq_number_o),
  .ack_number_i    (ack_number_o),
  .flag_bits_i     (flag_bits_o),
  .window_i        (window_o)
);

/* tb/tcphp_segment_checker.sv */
`timescale 1ns / 100ps

// Watches both channels of the TCP header parser. It predicts the result items
// from the accepted bytes and compares each result item with the oldest prediction.
module tcphp_segment_checker
  import tcphp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  input  logic [31:0] pseudo_sum_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [7:0]  payload_byte_i,
  input  logic        payload_valid_i,
  input  logic        done_res_i,
  input  logic [1:0]  status_i,
  input  logic [15:0] source_port_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] seq_number_i,
  input  logic [31:0] ack_number_i,
  input  logic [3:0]  flag_bits_i,
  input  logic [15:0] window_i,
  output int          mismatches_o,
  output int          pending_o
);

  // Parser state as the segment is seen from outside.
  logic [PosBits-1:0] seg_pos;
  logic [31:0]        sum_acc;
  logic [7:0]         held_high;
  logic               high_held;
  logic [15:0]        hdr_src;
  logic [15:0]        hdr_dst;
  logic [31:0]        hdr_seq;
  logic [31:0]        hdr_ack;
  logic [3:0]         hdr_offset;
  logic [3:0]         hdr_flags;
  logic [15:0]        hdr_window;

  res_t results_due[$];
  int   mismatches;

  // 32-bit add with the carry wrapped back into bit zero.
  function automatic logic [31:0] ones_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[31:0] + 32'(s[32]);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Works out what one accepted byte produces and queues it.
  task automatic predict_segment_byte(input logic [7:0] b, input logic last,
                                      input logic [31:0] psum);
    res_t        r;
    logic [31:0] folded;
    logic        is_payload;
    int          p;
    int          seg_len;

    p = int'(seg_pos);
    is_payload = 1'b0;

    // The first byte of a segment loads the pseudo-header sum and clears the header.
    if (p == 0) begin
      sum_acc    = psum;
      high_held  = 1'b0;
      hdr_src    = '0;
      hdr_dst    = '0;
      hdr_seq    = '0;
      hdr_ack    = '0;
      hdr_offset = '0;
      hdr_flags  = '0;
      hdr_window = '0;
    end

    // Bytes pair into big-endian words; an odd last byte is padded with zero.
    if (!high_held) begin
      held_high = b;
      high_held = 1'b1;
      if (last) begin
        sum_acc = ones_add(sum_acc, {16'd0, b, 8'd0});
      end
    end else begin
      sum_acc   = ones_add(sum_acc, {16'd0, held_high, b});
      high_held = 1'b0;
    end

    // Fixed header capture, then options are skipped and, with a valid data offset, the rest is payload.
    if (p < 2) begin
      hdr_src = {hdr_src[7:0], b};
    end else if (p < 4) begin
      hdr_dst = {hdr_dst[7:0], b};
    end else if (p < 8) begin
      hdr_seq = {hdr_seq[23:0], b};
    end else if (p < 12) begin
      hdr_ack = {hdr_ack[23:0], b};
    end else if (p == 12) begin
      hdr_offset = b[7:4];
    end else if (p == 13) begin
      hdr_flags = {b[4], b[2:0]};
    end else if (p < 16) begin
      hdr_window = {hdr_window[7:0], b};
    end else if (hdr_offset >= MinOffsetWords && p >= int'(hdr_offset) * 4) begin
      is_payload = 1'b1;
    end

    r = '0;
    if (is_payload) begin
      r.payload_byte  = b;
      r.payload_valid = 1'b1;
    end

    if (last) begin
      folded = sum_acc;
      while (folded > 32'h0000_FFFF) begin
        folded = (folded >> 16) + (folded & 32'h0000_FFFF);
      end
      seg_len = p + 1;
      // A bad checksum wins over every other status.
      if (folded != 32'h0000_FFFF) begin
        r.status = StBadSum;
      end else if (seg_len < int'(FixedHeaderBytes)) begin
        r.status = StTrunc;
      end else if (hdr_offset < MinOffsetWords) begin
        r.status = StOffset;
      end else if (seg_len < int'(hdr_offset) * 4) begin
        r.status = StTrunc;
      end else begin
        r.status = StOk;
      end
      r.done_res    = 1'b1;
      r.source_port = hdr_src;
      r.dest_port   = hdr_dst;
      r.seq_number  = hdr_seq;
      r.ack_number  = hdr_flags[3] ? hdr_ack : 32'd0;
      r.flag_bits   = hdr_flags;
      r.window      = hdr_window;
      seg_pos       = '0;
    end else if (seg_pos != PosMax) begin
      seg_pos = seg_pos + 1'b1;
    end

    if (is_payload || last) begin
      results_due.push_back(r);
    end
  endtask

  // Prediction on the input channel, comparison on the output channel.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    res_t want;
    if (!rst_ni) begin
      seg_pos      = '0;
      sum_acc      = '0;
      held_high    = '0;
      high_held    = 1'b0;
      hdr_src      = '0;
      hdr_dst      = '0;
      hdr_seq      = '0;
      hdr_ack      = '0;
      hdr_offset   = '0;
      hdr_flags    = '0;
      hdr_window   = '0;
      mismatches   = 0;
      results_due.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_segment_byte(data_byte_i, last_byte_i, pseudo_sum_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (results_due.size() == 0) begin
          $error("Result item with no prediction waiting: payload 0x%0h, done %0b",
                 payload_byte_i, done_res_i);
          mismatches++;
        end else begin
          want = results_due.pop_front();
          check_field("payload_byte", 32'(want.payload_byte), 32'(payload_byte_i));
          check_field("payload_valid", 32'(want.payload_valid), 32'(payload_valid_i));
          check_field("done_res", 32'(want.done_res), 32'(done_res_i));
          check_field("status", 32'(want.status), 32'(status_i));
          check_field("source_port", 32'(want.source_port), 32'(source_port_i));
          check_field("dest_port", 32'(want.dest_port), 32'(dest_port_i));
          check_field("seq_number", want.seq_number, seq_number_i);
          check_field("ack_number", want.ack_number, ack_number_i);
          check_field("flag_bits", 32'(want.flag_bits), 32'(flag_bits_i));
          check_field("window", 32'(want.window), 32'(window_i));
        end
      end
      mismatches_o <= mismatches;
      pending_o    <= results_due.size();
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

// Builds TCP segments, sends them byte by byte into the parser with random gaps
// and output stalls, and gives the verdict from the checker's mismatch count.
module testbench;
  import tcphp_pkg::*;

  localparam int RandomBytes = 700;
  localparam int CycleLimit = 2_000_000;

  typedef enum logic [2:0] {
    SegGood,
    SegBadSum,
    SegShort,
    SegLowOffset,
    SegCutOptions
  } seg_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  data_byte = 8'h00;
  logic        last_byte = 1'b0;
  logic [31:0] pseudo_sum = 32'h0;
  logic        out_stall = 1'b0;

  logic        in_stall;
  logic        out_valid;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        done_res;
  logic [1:0]  status;
  logic [15:0] source_port;
  logic [15:0] dest_port;
  logic [31:0] seq_number;
  logic [31:0] ack_number;
  logic [3:0]  flag_bits;
  logic [15:0] window;

  int mismatches;
  int pending;
  int bytes_sent = 0;
  int cycle_count = 0;
  int stall_run = 0;

  logic [7:0] seg_bytes[$];

  tcp_header_parse_check dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .pseudo_sum_i    (pseudo_sum),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .payload_byte_o  (payload_byte),
    .payload_valid_o (payload_valid),
    .done_res_o      (done_res),
    .status_o        (status),
    .source_port_o   (source_port),
    .dest_port_o     (dest_port),
    .seq_number_o    (seq_number),
    .ack_number_o    (ack_number),
    .flag_bits_o     (flag_bits),
    .window_o        (window)
  );

  tcphp_segment_checker checker_inst (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .data_byte_i     (data_byte),
    .last_byte_i     (last_byte),
    .pseudo_sum_i    (pseudo_sum),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .payload_byte_i  (payload_byte),
    .payload_valid_i (payload_valid),
    .done_res_i      (done_res),
    .status_i        (status),
    .source_port_i   (source_port),
    .dest_port_i     (dest_port),
    .seq_number_i    (seq_number),
    .ack_number_i    (ack_number),
    .flag_bits_i     (flag_bits),
    .window_i        (window),
    .mismatches_o    (mismatches),
    .pending_o       (pending)
  );

  always #5 clk_i = ~clk_i;

  // Guards against a hang.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("tcp_header_parse_check verification failed");
      $finish;
    end
  end

  // Output stall: short bursts mostly, a few long ones, and some long free runs.
  always @(posedge clk_i) begin : out_stall_gen
    int r;
    r = $urandom_range(0, 99);
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      out_stall <= !out_stall;
      if (out_stall) begin
        stall_run <= (r < 60) ? $urandom_range(0, 3) :
                     (r < 90) ? $urandom_range(4, 30) : $urandom_range(50, 200);
      end else begin
        stall_run <= (r < 80) ? $urandom_range(0, 2) :
                     (r < 96) ? $urandom_range(3, 10) : $urandom_range(20, 60);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  // Pseudo-header sum that makes the whole segment fold to all ones. The upper
  // bits are a random multiple of 0xFFFF, which leaves the folded sum unchanged.
  function automatic logic [31:0] good_pseudo();
    longint unsigned acc;
    longint unsigned k;
    acc = 0;
    for (int i = 0; i < seg_bytes.size(); i += 2) begin
      acc += {seg_bytes[i], (i + 1 < seg_bytes.size()) ? seg_bytes[i + 1] : 8'h00};
    end
    while (acc > 64'hFFFF) begin
      acc = (acc >> 16) + (acc & 64'hFFFF);
    end
    k = $urandom_range(0, 65536);
    return 32'(k * 65535 + {48'd0, ~acc[15:0]});
  endfunction

  function automatic void add_random_bytes(input int n);
    repeat (n) seg_bytes.push_back(8'($urandom()));
  endfunction

  // Fixed 20-byte header with random ports, numbers, window and checksum field.
  function automatic void make_header(input logic [3:0] off, input logic [7:0] flags);
    seg_bytes.delete();
    add_random_bytes(12);
    seg_bytes.push_back({off, 4'($urandom())});
    seg_bytes.push_back(flags);
    add_random_bytes(6);
  endfunction

  function automatic int pick_payload_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 12);
    if (r < 98) return $urandom_range(13, 60);
    return $urandom_range(100, 300);
  endfunction

  task automatic build_segment(input seg_kind_e kind, output logic [31:0] ps);
    logic [3:0] off;
    case (kind)
      SegGood, SegBadSum: begin
        off = ($urandom_range(0, 99) < 60) ? 4'd5 : 4'($urandom_range(6, 15));
        make_header(off, 8'($urandom()));
        add_random_bytes((int'(off) - 5) * 4 + pick_payload_len());
      end
      SegShort: begin
        seg_bytes.delete();
        add_random_bytes($urandom_range(1, 19));
      end
      SegLowOffset: begin
        make_header(4'($urandom_range(0, 4)), 8'($urandom()));
        add_random_bytes($urandom_range(0, 30));
      end
      default: begin
        // Segment ends inside its own options.
        off = 4'($urandom_range(6, 15));
        make_header(off, 8'($urandom()));
        add_random_bytes($urandom_range(0, int'(off) * 4 - 21));
      end
    endcase
    ps = good_pseudo();
    if (kind == SegBadSum) begin
      ps = ps ^ (32'd1 << $urandom_range(0, 15));
    end else if (kind == SegShort && $urandom_range(0, 3) == 0) begin
      ps = $urandom();
    end
  endtask

  // One item on the input channel; waits until the block takes it.
  task automatic send_byte(input logic [7:0] b, input logic last, input logic [31:0] ps,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    data_byte  <= b;
    last_byte  <= last;
    pseudo_sum <= ps;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Sends seg_bytes; the pseudo sum matters on the first byte only.
  task automatic send_segment(input logic [31:0] ps, input bit no_gaps);
    foreach (seg_bytes[i]) begin
      send_byte(seg_bytes[i], i == seg_bytes.size() - 1, (i == 0) ? ps : 32'($urandom()),
                no_gaps ? 0 : pick_gap());
    end
  endtask

  initial begin : stimulus
    logic [31:0] ps;
    int          random_end;
    int          r;
    seg_kind_e   kind;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // One-byte segments: all-ones byte with a good sum, the largest pseudo sum
    // on a zero byte, and a zero sum that fails the check.
    seg_bytes = '{8'hFF};
    send_segment(good_pseudo(), 1'b0);
    seg_bytes = '{8'h00};
    send_segment(32'hFFFF_FFFF, 1'b0);
    seg_bytes = '{8'h00};
    send_segment(32'h0000_0000, 1'b0);

    // All-ones header: every flag set, offset fifteen, so it is cut short.
    seg_bytes.delete();
    repeat (20) seg_bytes.push_back(8'hFF);
    send_segment(good_pseudo(), 1'b0);

    // All-zero header with offset five: clean, ACK clear.
    seg_bytes.delete();
    repeat (20) seg_bytes.push_back(8'h00);
    seg_bytes[12] = 8'h50;
    send_segment(good_pseudo(), 1'b0);

    // ACK set with an odd-length payload.
    make_header(4'd5, 8'h10);
    seg_bytes.push_back(8'h00);
    seg_bytes.push_back(8'hFF);
    seg_bytes.push_back(8'hA5);
    send_segment(good_pseudo(), 1'b1);

    // Data offsets under five never mark payload.
    make_header(4'd4, 8'h17);
    add_random_bytes(4);
    send_segment(good_pseudo(), 1'b0);
    make_header(4'd0, 8'h12);
    send_segment(good_pseudo(), 1'b0);

    // Options then payload, with a broken checksum.
    make_header(4'd6, 8'h1F);
    add_random_bytes(6);
    send_segment(good_pseudo() ^ 32'd1, 1'b0);

    // Good checksum on partial headers and on a segment ending in its options.
    seg_bytes.delete();
    add_random_bytes(10);
    send_segment(good_pseudo(), 1'b0);
    seg_bytes.delete();
    add_random_bytes(19);
    send_segment(good_pseudo(), 1'b0);
    make_header(4'd9, 8'h10);
    add_random_bytes(8);
    send_segment(good_pseudo(), 1'b0);

    // Random segments, mostly well formed.
    random_end = bytes_sent + RandomBytes;
    while (bytes_sent < random_end) begin
      r = $urandom_range(0, 99);
      kind = (r < 66) ? SegGood : (r < 76) ? SegBadSum : (r < 84) ? SegShort :
             (r < 92) ? SegLowOffset : SegCutOptions;
      build_segment(kind, ps);
      send_segment(ps, $urandom_range(0, 3) == 0);
    end

    // One more well-formed segment to finish.
    build_segment(SegGood, ps);
    send_segment(ps, 1'b0);
    in_valid <= 1'b0;

    do @(posedge clk_i); while (pending != 0);
    repeat (20) @(posedge clk_i);

    if (mismatches == 0 && pending == 0) begin
      $display("tcp_header_parse_check verification clean");
    end else begin
      $display("tcp_header_parse_check verification failed");
    end
    $finish;
  end

endmodule
